FILE: hw/rtl/lis_pkg.sv
package lis_pkg;

	// register indexes on the configuration port
	typedef enum logic [2:0] {
		CFG_TEMP_LOW  = 3'd0,
		CFG_TEMP_HIGH = 3'd1,
		CFG_VOL_LOW   = 3'd2,
		CFG_VOL_HIGH  = 3'd3,
		CFG_PRES_LOW  = 3'd4,
		CFG_PRES_HIGH = 3'd5
	} lis_cfg_idx_t;

	localparam int TEMP_W = 24;
	localparam int VAL_W  = 32;
	localparam int WGT_W  = TEMP_W + 1;      // temperature differences
	localparam int PRD_W  = VAL_W + 1 + WGT_W; // signed value * weight
	localparam int NV_W   = PRD_W + 1;       // signed interpolated volume term
	localparam int DS_W   = PRD_W + 2;       // signed denominator
	localparam int NM_W   = NV_W - 1;        // volume magnitude
	localparam int NUM_W  = NM_W + VAL_W;    // full numerator magnitude
	localparam int DEN_W  = DS_W;            // denominator magnitude
	localparam int QUO_W  = 32;

	localparam logic [TEMP_W-1:0] TEMP_LOW_RST  = 24'sd0;
	localparam logic [TEMP_W-1:0] TEMP_HIGH_RST = 24'sd256;
	localparam logic [VAL_W-1:0]  VOL_RST       = 32'd0;
	localparam logic [VAL_W-1:0]  PRES_RST      = 32'd65536;

	localparam logic [QUO_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [QUO_W-1:0] NEG_LIMIT = 32'h8000_0000;

	// word handed from the arithmetic front to the divider
	typedef struct packed {
		logic             valid;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
		logic             neg;
		logic             derr;
		logic             inr;
	} lis_quo_t;

	// finished result word
	typedef struct packed {
		logic             valid;
		logic [QUO_W-1:0] vol;
		logic             inr;
		logic             derr;
	} lis_res_t;

endpackage

FILE: hw/rtl/langmuir_isotherm_interp.sv
// channel  | strobe / qualifier | words
// ---------+--------------------+---------------------------------------------
// input    | start & !busy      | temperature, pressure
// result   | done               | adsorbed_volume, in_range, divide_error
// config   | cfg_we             | cfg_index, cfg_wdata
//
// One word accepted per cycle; busy stays low. Each result passes through six
// arithmetic stages, an entry stage and one divider stage per quotient bit, and
// the output register; the bit-serial divider pipeline sets that depth.
// Reset clears valid bits and loads register defaults; results cannot be stalled.
module langmuir_isotherm_interp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [lis_pkg::TEMP_W-1:0] temperature,
	input  logic [lis_pkg::VAL_W-1:0]         pressure,
	output logic                              done,
	output logic signed [lis_pkg::QUO_W-1:0]  adsorbed_volume,
	output logic                              in_range,
	output logic                              divide_error,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [lis_pkg::VAL_W-1:0]         cfg_wdata
);

	localparam int LAT = 40;

	logic signed [lis_pkg::TEMP_W-1:0] t_low_q, t_high_q;
	logic [lis_pkg::VAL_W-1:0] vl_low_q, vl_high_q, pl_low_q, pl_high_q;
	lis_pkg::lis_quo_t quo;
	lis_pkg::lis_res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_low_q   <= lis_pkg::TEMP_LOW_RST;
			t_high_q  <= lis_pkg::TEMP_HIGH_RST;
			vl_low_q  <= lis_pkg::VOL_RST;
			vl_high_q <= lis_pkg::VOL_RST;
			pl_low_q  <= lis_pkg::PRES_RST;
			pl_high_q <= lis_pkg::PRES_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				lis_pkg::CFG_TEMP_LOW:  t_low_q   <= cfg_wdata[lis_pkg::TEMP_W-1:0];
				lis_pkg::CFG_TEMP_HIGH: t_high_q  <= cfg_wdata[lis_pkg::TEMP_W-1:0];
				lis_pkg::CFG_VOL_LOW:   vl_low_q  <= cfg_wdata;
				lis_pkg::CFG_VOL_HIGH:  vl_high_q <= cfg_wdata;
				lis_pkg::CFG_PRES_LOW:  pl_low_q  <= cfg_wdata;
				lis_pkg::CFG_PRES_HIGH: pl_high_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	lis_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (start & ~busy),
		.temperature (temperature),
		.pressure    (pressure),
		.t_low       (t_low_q),
		.t_high      (t_high_q),
		.vl_low      (vl_low_q),
		.vl_high     (vl_high_q),
		.pl_low      (pl_low_q),
		.pl_high     (pl_high_q),
		.quo         (quo)
	);

	lis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.quo    (quo),
		.res    (res)
	);

	assign done            = res.valid;
	assign adsorbed_volume = res.vol;
	assign in_range        = res.inr;
	assign divide_error    = res.derr;

	// every accepted word comes out after the fixed pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result strobe missing after pipeline latency");

	// no result without an accepted word at the matching cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !$past(start && !busy, LAT)) |-> 1'b0)
		else $error("result strobe without input word");

	// divide error forces a zero volume
	a_derr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_error) |-> (adsorbed_volume == '0))
		else $error("nonzero volume on divide error");

endmodule

FILE: hw/rtl/lis_front.sv
module lis_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [lis_pkg::TEMP_W-1:0] temperature,
	input  logic [lis_pkg::VAL_W-1:0]         pressure,
	input  logic signed [lis_pkg::TEMP_W-1:0] t_low,
	input  logic signed [lis_pkg::TEMP_W-1:0] t_high,
	input  logic [lis_pkg::VAL_W-1:0]         vl_low,
	input  logic [lis_pkg::VAL_W-1:0]         vl_high,
	input  logic [lis_pkg::VAL_W-1:0]         pl_low,
	input  logic [lis_pkg::VAL_W-1:0]         pl_high,
	output lis_pkg::lis_quo_t                 quo
);

	localparam int TW = lis_pkg::TEMP_W;
	localparam int VW = lis_pkg::VAL_W;
	localparam int WW = lis_pkg::WGT_W;
	localparam int PW = lis_pkg::PRD_W;
	localparam int NVW = lis_pkg::NV_W;
	localparam int DSW = lis_pkg::DS_W;
	localparam int NMW = lis_pkg::NM_W;
	localparam int NUMW = lis_pkg::NUM_W;
	localparam int HIW = NMW - VW;

	logic [6:1] vld;

	// s1: weights and span
	logic signed [WW-1:0] wa_s1, wb_s1, span_s1;
	logic [VW-1:0] p_s1, p_s2, p_s3, p_s4;
	logic inr_s1, inr_s2, inr_s3, inr_s4, inr_s5, inr_s6;
	// s2: products
	logic signed [PW-1:0] vla_s2, vlb_s2, pla_s2, plb_s2, ps_s2;
	// s3: numerator and denominator
	logic signed [NVW-1:0] nv_s3;
	logic signed [DSW-1:0] den_s3;
	// s4: magnitudes
	logic [NMW-1:0] nm_s4;
	logic [DSW-1:0] dm_s4, dm_s5, dm_s6;
	logic neg_s4, neg_s5, neg_s6, derr_s4, derr_s5, derr_s6;
	// s5: partial products
	logic [2*VW-1:0] pplo_s5;
	logic [HIW+VW-1:0] pphi_s5;
	// s6: full numerator
	logic [NUMW-1:0] num_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld <= '0;
		end else begin
			vld <= {vld[5:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// s1
		wa_s1   <= WW'(t_high) - WW'(temperature);
		wb_s1   <= WW'(temperature) - WW'(t_low);
		span_s1 <= WW'(t_high) - WW'(t_low);
		p_s1    <= pressure;
		inr_s1  <= (t_low <= temperature) && (temperature <= t_high);
		// s2
		vla_s2 <= PW'($signed({1'b0, vl_low}) * wa_s1);
		vlb_s2 <= PW'($signed({1'b0, vl_high}) * wb_s1);
		pla_s2 <= PW'($signed({1'b0, pl_low}) * wa_s1);
		plb_s2 <= PW'($signed({1'b0, pl_high}) * wb_s1);
		ps_s2  <= PW'($signed({1'b0, p_s1}) * span_s1);
		p_s2   <= p_s1;
		inr_s2 <= inr_s1;
		// s3
		nv_s3  <= NVW'(vla_s2) + NVW'(vlb_s2);
		den_s3 <= DSW'(pla_s2) + DSW'(plb_s2) + DSW'(ps_s2);
		p_s3   <= p_s2;
		inr_s3 <= inr_s2;
		// s4
		nm_s4   <= nv_s3[NVW-1] ? NMW'(-nv_s3) : NMW'(nv_s3);
		dm_s4   <= den_s3[DSW-1] ? DSW'(-den_s3) : DSW'(den_s3);
		neg_s4  <= nv_s3[NVW-1] != den_s3[DSW-1];
		derr_s4 <= den_s3 == '0;
		p_s4    <= p_s3;
		inr_s4  <= inr_s3;
		// s5
		pplo_s5 <= nm_s4[VW-1:0] * p_s4;
		pphi_s5 <= nm_s4[NMW-1:VW] * p_s4;
		dm_s5   <= dm_s4;
		neg_s5  <= neg_s4;
		derr_s5 <= derr_s4;
		inr_s5  <= inr_s4;
		// s6
		num_s6  <= {pphi_s5, {VW{1'b0}}} + NUMW'(pplo_s5);
		dm_s6   <= dm_s5;
		neg_s6  <= neg_s5;
		derr_s6 <= derr_s5;
		inr_s6  <= inr_s5;
	end

	assign quo.valid = vld[6];
	assign quo.num   = num_s6;
	assign quo.den   = dm_s6;
	assign quo.neg   = neg_s6;
	assign quo.derr  = derr_s6;
	assign quo.inr   = inr_s6;

endmodule

FILE: hw/rtl/lis_div.sv
module lis_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lis_pkg::lis_quo_t quo,
	output lis_pkg::lis_res_t res
);

	localparam int QW = lis_pkg::QUO_W;
	localparam int RW = lis_pkg::DEN_W;
	localparam int NW = lis_pkg::NUM_W;

	logic [QW:0]    vld_s;
	logic [RW-1:0]  rem_s  [0:QW];
	logic [RW-1:0]  den_s  [0:QW];
	logic [QW-1:0]  nlo_s  [0:QW];
	logic [QW-1:0]  q_s    [0:QW];
	logic [QW:0]    ovf_s, neg_s, derr_s, inr_s;
	logic           res_vld_q;
	logic [QW-1:0]  res_vol_q;
	logic           res_inr_q, res_derr_q;

	// entry: upper numerator bits form the first remainder
	always_ff @(posedge clk) begin
		rem_s[0]  <= RW'(quo.num[NW-1:QW]);
		nlo_s[0]  <= quo.num[QW-1:0];
		den_s[0]  <= quo.den;
		q_s[0]    <= '0;
		ovf_s[0]  <= RW'(quo.num[NW-1:QW]) >= quo.den;
		neg_s[0]  <= quo.neg;
		derr_s[0] <= quo.derr;
		inr_s[0]  <= quo.inr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[QW-1:0], quo.valid};
		end
	end

	// one restoring quotient bit per stage
	for (genvar k = 0; k < QW; k++) begin : g_bit
		logic [RW:0] sh;
		logic        ge;
		assign sh = {rem_s[k], nlo_s[k][QW-1]};
		assign ge = sh >= {1'b0, den_s[k]};
		always_ff @(posedge clk) begin
			rem_s[k+1]  <= ge ? RW'(sh - {1'b0, den_s[k]}) : RW'(sh);
			nlo_s[k+1]  <= {nlo_s[k][QW-2:0], 1'b0};
			den_s[k+1]  <= den_s[k];
			q_s[k+1]    <= {q_s[k][QW-2:0], ge};
			ovf_s[k+1]  <= ovf_s[k];
			neg_s[k+1]  <= neg_s[k];
			derr_s[k+1] <= derr_s[k];
			inr_s[k+1]  <= inr_s[k];
		end
	end

	// saturate, apply sign, zero on divide error
	logic [QW-1:0] lim, mag, sval;
	always_comb begin
		lim  = neg_s[QW] ? lis_pkg::NEG_LIMIT : lis_pkg::POS_LIMIT;
		mag  = (ovf_s[QW] || q_s[QW] > lim) ? lim : q_s[QW];
		sval = neg_s[QW] ? QW'(-mag) : mag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else begin
			res_vld_q <= vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		res_vol_q  <= derr_s[QW] ? '0 : sval;
		res_inr_q  <= inr_s[QW];
		res_derr_q <= derr_s[QW];
	end

	assign res.valid = res_vld_q;
	assign res.vol   = res_vol_q;
	assign res.inr   = res_inr_q;
	assign res.derr  = res_derr_q;

endmodule

FILE: sim/langmuir_isotherm_interp_chk.sv
`timescale 1ns / 1ps

// Watches the input, result and register channels of the isotherm block,
// predicts each result word and compares it with what comes out.
module langmuir_isotherm_interp_chk (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic signed [lis_pkg::TEMP_W-1:0] temperature,
	input  logic [lis_pkg::VAL_W-1:0]         pressure,
	input  logic                              done,
	input  logic signed [lis_pkg::QUO_W-1:0]  adsorbed_volume,
	input  logic                              in_range,
	input  logic                              divide_error,
	input  logic                              cfg_we,
	input  logic [2:0]                        cfg_index,
	input  logic [lis_pkg::VAL_W-1:0]         cfg_wdata,
	output int                                errors,
	output int                                pending
);

	typedef struct {
		logic [lis_pkg::QUO_W-1:0] vol;
		logic                      inr;
		logic                      derr;
	} uptake_t;

	// shadow copy of the interpolation registers
	longint t_lo, t_hi, vol_lo, vol_hi, pres_lo, pres_hi;
	uptake_t uptake_q[$];
	int words_in, words_out;

	assign pending = words_in - words_out;

	// adsorbed volume for one word under the current register settings
	function automatic uptake_t isotherm(logic signed [lis_pkg::TEMP_W-1:0] t_in,
			logic [lis_pkg::VAL_W-1:0] p_in);
		uptake_t r;
		longint t, p, span, wa, wb, nvl, npl, den;
		logic [127:0] nm, dm, quo, lim;
		logic neg;
		t = longint'(t_in);
		p = longint'({32'd0, p_in});
		span = t_hi - t_lo;
		wa = t_hi - t;
		wb = t - t_lo;
		nvl = vol_lo * wa + vol_hi * wb;
		npl = pres_lo * wa + pres_hi * wb;
		den = npl + p * span;
		r.inr = (t_lo <= t) && (t <= t_hi);
		r.derr = (den == 0);
		r.vol = '0;
		if (den != 0) begin
			neg = (nvl < 0) != (den < 0);
			nm = 128'(nvl < 0 ? -nvl : nvl);
			dm = 128'(den < 0 ? -den : den);
			// truncate the magnitude, then saturate and apply the sign
			quo = (nm * 128'(p)) / dm;
			lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
			if (quo > lim)
				quo = lim;
			r.vol = neg ? -quo[31:0] : quo[31:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		uptake_t want;
		if (!arst_n) begin
			t_lo = longint'($signed(lis_pkg::TEMP_LOW_RST));
			t_hi = longint'($signed(lis_pkg::TEMP_HIGH_RST));
			vol_lo = longint'({32'd0, lis_pkg::VOL_RST});
			vol_hi = longint'({32'd0, lis_pkg::VOL_RST});
			pres_lo = longint'({32'd0, lis_pkg::PRES_RST});
			pres_hi = longint'({32'd0, lis_pkg::PRES_RST});
			uptake_q.delete();
			words_in = 0;
			words_out = 0;
			errors = 0;
		end else begin
			// accepted input word sees the registers as they were before this edge
			if (start && !busy) begin
				uptake_q.push_back(isotherm(temperature, pressure));
				words_in++;
			end
			// register writes
			if (cfg_we) begin
				case (lis_pkg::lis_cfg_idx_t'(cfg_index))
					lis_pkg::CFG_TEMP_LOW:
						t_lo = longint'($signed(cfg_wdata[lis_pkg::TEMP_W-1:0]));
					lis_pkg::CFG_TEMP_HIGH:
						t_hi = longint'($signed(cfg_wdata[lis_pkg::TEMP_W-1:0]));
					lis_pkg::CFG_VOL_LOW:   vol_lo = longint'({32'd0, cfg_wdata});
					lis_pkg::CFG_VOL_HIGH:  vol_hi = longint'({32'd0, cfg_wdata});
					lis_pkg::CFG_PRES_LOW:  pres_lo = longint'({32'd0, cfg_wdata});
					lis_pkg::CFG_PRES_HIGH: pres_hi = longint'({32'd0, cfg_wdata});
					default: ;
				endcase
			end
			// result word
			if (done) begin
				words_out++;
				if (uptake_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result word vol=%h inr=%b derr=%b", $time,
						adsorbed_volume, in_range, divide_error);
				end else begin
					want = uptake_q.pop_front();
					if (adsorbed_volume !== want.vol) begin
						errors++;
						$display("%0t: adsorbed_volume expected %h actual %h", $time,
							want.vol, adsorbed_volume);
					end
					if (in_range !== want.inr) begin
						errors++;
						$display("%0t: in_range expected %b actual %b", $time,
							want.inr, in_range);
					end
					if (divide_error !== want.derr) begin
						errors++;
						$display("%0t: divide_error expected %b actual %b", $time,
							want.derr, divide_error);
					end
				end
			end
		end
	end

endmodule

FILE: sim/langmuir_isotherm_interp_tb.sv
`timescale 1ns / 1ps

module langmuir_isotherm_interp_tb;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN = 50;

	logic clk, arst_n, start, busy, done, in_range, divide_error, cfg_we;
	logic signed [lis_pkg::TEMP_W-1:0] temperature;
	logic [lis_pkg::VAL_W-1:0] pressure, cfg_wdata;
	logic signed [lis_pkg::QUO_W-1:0] adsorbed_volume;
	logic [2:0] cfg_index;
	int errors, pending, cycles;
	int t_lo_now, t_hi_now;

	langmuir_isotherm_interp dut (.*);
	langmuir_isotherm_interp_chk chk (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("langmuir_isotherm_interp_tb failed");
			$finish;
		end
	end

	task automatic write_reg(lis_pkg::lis_cfg_idx_t idx, logic [lis_pkg::VAL_W-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == lis_pkg::CFG_TEMP_LOW)
			t_lo_now = $signed(val[lis_pkg::TEMP_W-1:0]);
		if (idx == lis_pkg::CFG_TEMP_HIGH)
			t_hi_now = $signed(val[lis_pkg::TEMP_W-1:0]);
	endtask

	task automatic set_interval(int tl, int th, logic [31:0] vl, logic [31:0] vh,
			logic [31:0] pl, logic [31:0] ph);
		write_reg(lis_pkg::CFG_TEMP_LOW, 32'(tl));
		write_reg(lis_pkg::CFG_TEMP_HIGH, 32'(th));
		write_reg(lis_pkg::CFG_VOL_LOW, vl);
		write_reg(lis_pkg::CFG_VOL_HIGH, vh);
		write_reg(lis_pkg::CFG_PRES_LOW, pl);
		write_reg(lis_pkg::CFG_PRES_HIGH, ph);
	endtask

	// hold start low until every result is back and the pipeline is empty
	task automatic drain();
		start = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	// present one word and hold it until accepted
	task automatic send(int t, logic [31:0] p);
		start = 1'b1;
		temperature = lis_pkg::TEMP_W'(t);
		pressure = p;
		do
			@(posedge clk);
		while (busy);
		@(negedge clk);
	endtask

	task automatic idle(int n);
		start = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0010_0000);
			2: return $urandom_range(32'h0400_0000);
			default: return {1'($urandom_range(1)), 31'd0} | $urandom_range(32'hFFFF);
		endcase
	endfunction

	function automatic int rand_temp();
		int a, b;
		case ($urandom_range(4))
			0: return $signed($urandom_range(32'hFFFFFF) << 8) >>> 8;
			1: return -8388608 + $urandom_range(32'hFF);
			2: return 8388607 - $urandom_range(32'hFF);
			default: begin
				a = t_lo_now < t_hi_now ? t_lo_now : t_hi_now;
				b = t_lo_now < t_hi_now ? t_hi_now : t_lo_now;
				a = a - 64 < -8388608 ? -8388608 : a - 64;
				b = b + 64 > 8388607 ? 8388607 : b + 64;
				return a + int'($urandom_range(b - a));
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_pressure();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(32'h0008_0000);
			2: return $urandom_range(3) == 0 ? 32'd0 : 32'hFFFF_FFFF;
			default: return $urandom_range(32'hFFFF);
		endcase
	endfunction

	task automatic random_config();
		int tl, th;
		case ($urandom_range(5))
			0: begin
				tl = $signed($urandom_range(32'hFFFFFF) << 8) >>> 8;
				th = $signed($urandom_range(32'hFFFFFF) << 8) >>> 8;
			end
			1: begin
				tl = -8388608;
				th = 8388607;
			end
			2: begin
				tl = int'($urandom_range(4000)) - 2000;
				th = tl;
			end
			default: begin
				tl = int'($urandom_range(20000)) - 10000;
				th = tl + int'($urandom_range(5000));
			end
		endcase
		set_interval(tl, th, rand_value(), rand_value(), rand_value(), rand_value());
	endtask

	initial begin
		int burst;
		cycles = 0;
		start = 1'b0;
		temperature = '0;
		pressure = '0;
		cfg_we = 1'b0;
		cfg_index = 3'd0;
		cfg_wdata = '0;
		t_lo_now = 0;
		t_hi_now = 256;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// register defaults: zero volume everywhere
		send(128, 32'h0001_0000);
		send(-8388608, 32'hFFFF_FFFF);
		drain();

		// ordinary isotherm with extremes of both fields
		set_interval(0, 256, 32'h0064_0000, 32'h00C8_0000, 32'h0001_0000, 32'h0002_0000);
		send(0, 32'h0001_0000);
		send(256, 32'h0001_0000);
		send(128, 32'd0);
		send(128, 32'hFFFF_FFFF);
		send(-8388608, 32'h0001_0000);
		send(8388607, 32'h0001_0000);
		send(-1, 32'h0000_0001);
		send(257, 32'h8000_0000);
		drain();

		// zero denominator: no half pressure and no pressure
		set_interval(0, 256, 32'h0010_0000, 32'h0010_0000, 32'd0, 32'd0);
		send(100, 32'd0);
		send(-5, 32'd0);
		send(100, 32'd1);
		drain();

		// saturation, widest interval, largest values
		set_interval(-8388608, 8388607, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd0);
		send(-8388608, 32'hFFFF_FFFF);
		send(8388607, 32'hFFFF_FFFF);
		send(0, 32'd1);
		drain();

		// reversed interval, negative results, then a zero span
		set_interval(256, -256, 32'h0100_0000, 32'd0, 32'h0001_0000, 32'h0003_0000);
		send(0, 32'h0002_0000);
		send(300, 32'h0000_8000);
		send(-300, 32'hFFFF_FFFF);
		drain();
		set_interval(64, 64, 32'h0001_0000, 32'h0002_0000, 32'h0001_0000, 32'h0001_0000);
		send(64, 32'd0);
		send(65, 32'h0001_0000);
		send(63, 32'h0001_0000);
		drain();

		// random phases: bursts of words with random gaps
		repeat (10) begin
			random_config();
			repeat (125) begin
				send(rand_temp(), rand_pressure());
				if ($urandom_range(3) == 0) begin
					burst = $urandom_range(6);
					idle(burst);
				end
			end
			drain();
		end

		if (errors == 0)
			$display("langmuir_isotherm_interp_tb passed");
		else
			$display("langmuir_isotherm_interp_tb failed");
		$finish;
	end

endmodule
